### hw/rtl/lfcr_pkg.sv
// ----------------------------------------------------------------------------
// lfcr_pkg
// shared widths, phase codes and the result record of the frame receiver
// ----------------------------------------------------------------------------
package lfcr_pkg;

    // width kept for the declared payload length (8 to 32)
    localparam int LENGTH_BITS = 32;

    localparam int BYTE_W      = 8;
    localparam int LEN_W       = 32;            // reported frame_length width
    localparam int LEN_BYTES   = 4;
    localparam int CHECK_BYTES = 4;
    localparam int KEEP_BYTES  = 6;
    localparam int KEEP_IDX_W  = $clog2(KEEP_BYTES);
    localparam int CFG_IDX_W   = 8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_START_BYTE    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SETPIXEL_CODE = CFG_IDX_W'(1);

    localparam logic [BYTE_W-1:0] START_BYTE_RST    = 8'hAA;
    localparam logic [BYTE_W-1:0] SETPIXEL_CODE_RST = 8'h01;

    // receive phases
    localparam logic [1:0] PH_HUNT    = 2'd0;
    localparam logic [1:0] PH_LEN     = 2'd1;
    localparam logic [1:0] PH_PAYLOAD = 2'd2;
    localparam logic [1:0] PH_CHECK   = 2'd3;

    localparam int OUT_DATA_W = KEEP_BYTES * BYTE_W + LEN_W;

    typedef struct packed {
        logic [LEN_W-1:0]  frame_length;
        logic              is_setpixel;
        logic [BYTE_W-1:0] blue;
        logic [BYTE_W-1:0] green;
        logic [BYTE_W-1:0] red;
        logic [BYTE_W-1:0] pixel_y;
        logic [BYTE_W-1:0] pixel_x;
        logic [BYTE_W-1:0] command;
    } t_result;

endpackage

### hw/rtl/lfcr_deframer.sv
// ----------------------------------------------------------------------------
// lfcr_deframer
// per-byte frame state: hunt, length, payload, checksum; emits on last byte
// ----------------------------------------------------------------------------
module lfcr_deframer (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_beat,
    input  logic [lfcr_pkg::BYTE_W-1:0]         i_byte,
    input  logic [lfcr_pkg::BYTE_W-1:0]         i_start_byte,
    input  logic [lfcr_pkg::BYTE_W-1:0]         i_setpixel_code,
    output logic                                o_emit,
    output lfcr_pkg::t_result                   o_result
);

    logic [1:0]                         r_phase, n_phase;
    logic [lfcr_pkg::LENGTH_BITS-1:0]   r_count, n_count;
    logic [lfcr_pkg::LEN_W-1:0]         r_len,   n_len;
    logic [lfcr_pkg::BYTE_W-1:0]        r_hdr [lfcr_pkg::KEEP_BYTES];
    logic [lfcr_pkg::BYTE_W-1:0]        n_hdr [lfcr_pkg::KEEP_BYTES];

    logic [lfcr_pkg::LENGTH_BITS-1:0]   count_inc;
    logic [lfcr_pkg::LEN_W-1:0]         len_asm;
    logic [lfcr_pkg::LEN_W-1:0]         len_kept;

    assign count_inc = lfcr_pkg::LENGTH_BITS'(r_count + 1'b1);
    assign len_asm   = r_len | (lfcr_pkg::LEN_W'(i_byte) << {r_count[1:0], 3'b000});
    assign len_kept  = lfcr_pkg::LEN_W'(len_asm[lfcr_pkg::LENGTH_BITS-1:0]);

    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        n_len   = r_len;
        n_hdr   = r_hdr;
        o_emit  = 1'b0;
        if (i_beat) begin
            case (r_phase)
                lfcr_pkg::PH_HUNT: begin
                    if (i_byte == i_start_byte) begin
                        for (int k = 0; k < lfcr_pkg::KEEP_BYTES; k++) begin
                            n_hdr[k] = '0;
                        end
                        n_len   = '0;
                        n_count = '0;
                        n_phase = lfcr_pkg::PH_LEN;
                    end
                end
                lfcr_pkg::PH_LEN: begin
                    if (r_count[1:0] == 2'(lfcr_pkg::LEN_BYTES - 1)) begin
                        n_len   = len_kept;
                        n_count = '0;
                        n_phase = (len_kept == '0) ? lfcr_pkg::PH_CHECK
                                                   : lfcr_pkg::PH_PAYLOAD;
                    end else begin
                        n_len   = len_asm;
                        n_count = count_inc;
                    end
                end
                lfcr_pkg::PH_PAYLOAD: begin
                    if (r_count < lfcr_pkg::LENGTH_BITS'(lfcr_pkg::KEEP_BYTES)) begin
                        n_hdr[r_count[lfcr_pkg::KEEP_IDX_W-1:0]] = i_byte;
                    end
                    // length is nonzero here, so the count never wraps
                    if (count_inc == r_len[lfcr_pkg::LENGTH_BITS-1:0]) begin
                        n_count = '0;
                        n_phase = lfcr_pkg::PH_CHECK;
                    end else begin
                        n_count = count_inc;
                    end
                end
                lfcr_pkg::PH_CHECK: begin
                    if (r_count[1:0] == 2'(lfcr_pkg::CHECK_BYTES - 1)) begin
                        o_emit  = 1'b1;
                        n_len   = '0;
                        n_count = '0;
                        n_phase = lfcr_pkg::PH_HUNT;
                    end else begin
                        n_count = count_inc;
                    end
                end
                default: begin
                    n_phase = lfcr_pkg::PH_HUNT;
                end
            endcase
        end
    end

    always_comb begin
        o_result.command      = r_hdr[0];
        o_result.pixel_x      = r_hdr[1];
        o_result.pixel_y      = r_hdr[2];
        o_result.red          = r_hdr[3];
        o_result.green        = r_hdr[4];
        o_result.blue         = r_hdr[5];
        o_result.is_setpixel  = (r_hdr[0] == i_setpixel_code);
        o_result.frame_length = r_len;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= lfcr_pkg::PH_HUNT;
            r_count <= '0;
        end else begin
            r_phase <= n_phase;
            r_count <= n_count;
        end
    end

    // header and length are cleared at every start byte before any use
    always_ff @(posedge i_clk) begin
        r_len <= n_len;
        r_hdr <= n_hdr;
    end

    a_hunt_count_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == lfcr_pkg::PH_HUNT) |-> (r_count == '0))
        else $error("count not cleared while hunting");

    a_payload_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == lfcr_pkg::PH_PAYLOAD) |->
            (r_count < r_len[lfcr_pkg::LENGTH_BITS-1:0]))
        else $error("payload count beyond declared length");

    a_emit_returns_hunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_emit |=> (r_phase == lfcr_pkg::PH_HUNT))
        else $error("no return to hunting after a frame");

endmodule

### hw/rtl/lfcr_out_buf.sv
// ----------------------------------------------------------------------------
// lfcr_out_buf
// result register with a skid entry, so input beats keep flowing on a stall
// ----------------------------------------------------------------------------
module lfcr_out_buf (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  lfcr_pkg::t_result   i_result,
    output logic                o_full,
    output logic                o_valid,
    input  logic                i_ready,
    output lfcr_pkg::t_result   o_result
);

    logic               r_main_valid, r_skid_valid;
    lfcr_pkg::t_result  r_main, r_skid;
    logic               pop;

    assign pop      = r_main_valid && i_ready;
    assign o_valid  = r_main_valid;
    assign o_result = r_main;
    assign o_full   = r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) begin
                r_skid_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (r_main_valid && !pop) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_main_valid <= 1'b1;
            end
        end else if (pop) begin
            r_main_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (pop) begin
                r_main <= r_skid;
            end
        end else if (i_push) begin
            if (r_main_valid && !pop) begin
                r_skid <= i_result;
            end else begin
                r_main <= i_result;
            end
        end
    end

    a_skid_needs_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_main_valid)
        else $error("skid entry held without a head entry");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> !i_push)
        else $error("result pushed into a full buffer");

    a_stall_fills_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && r_main_valid && !i_ready) |=> r_skid_valid)
        else $error("stalled result lost");

endmodule

### hw/rtl/length_framed_command_receiver.sv
// ----------------------------------------------------------------------------
// length_framed_command_receiver
// deframes length-prefixed command frames from a received byte stream
// ----------------------------------------------------------------------------
// usage
//   slave stream: one received byte per beat in s_axis tdata
//   the receiver hunts for the start byte, then takes a 4-byte little-endian
//   payload length, the payload, and 4 checksum bytes (counted, not checked)
//   only the first six payload bytes are kept: command, x, y, r, g, b;
//   bytes not received read as zero, a zero length skips straight to checksum
//   master stream: one beat per frame, issued for the last checksum byte,
//   tuser is set when the command equals the set-pixel code
//   config channel: index 0 start byte (reset 0xAA), index 1 set-pixel code
//   (reset 0x01); other indexes are ignored; cfg_ready is always high
// timing
//   one byte per cycle while s_axis_tready is high; every byte is handled in
//   the cycle it is taken, and each result is registered for the master side
//   a result register plus one skid entry sit on the master side: s_axis_tready
//   drops only when both hold results, i.e. after two frames are stalled
// reset
//   synchronous active low; returns to hunting, clears both result entries
//   and reloads the config registers
// ----------------------------------------------------------------------------
module length_framed_command_receiver (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // byte input
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [lfcr_pkg::BYTE_W-1:0]         i_s_axis_tdata,   // [7:0] rx_byte
    // command output
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // [7:0] command, [15:8] pixel_x, [23:16] pixel_y, [31:24] red,
    // [39:32] green, [47:40] blue, [79:48] frame_length
    output logic [lfcr_pkg::OUT_DATA_W-1:0]     o_m_axis_tdata,
    output logic                                o_m_axis_tuser,   // [0] is_setpixel
    // config writes
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [lfcr_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [lfcr_pkg::BYTE_W-1:0]         i_cfg_data
);

    logic [lfcr_pkg::BYTE_W-1:0]    r_start_byte;
    logic [lfcr_pkg::BYTE_W-1:0]    r_setpixel_code;

    logic                           in_beat;
    logic                           emit;
    logic                           buf_full;
    lfcr_pkg::t_result              frame_result;
    lfcr_pkg::t_result              out_result;

    // config is always accepted
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte    <= lfcr_pkg::START_BYTE_RST;
            r_setpixel_code <= lfcr_pkg::SETPIXEL_CODE_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                lfcr_pkg::REG_START_BYTE:    r_start_byte    <= i_cfg_data;
                lfcr_pkg::REG_SETPIXEL_CODE: r_setpixel_code <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // take a byte whenever the output side still has a free entry
    assign o_s_axis_tready = !buf_full;
    assign in_beat         = i_s_axis_tvalid && o_s_axis_tready;

    lfcr_deframer u_deframer (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_beat          (in_beat),
        .i_byte          (i_s_axis_tdata),
        .i_start_byte    (r_start_byte),
        .i_setpixel_code (r_setpixel_code),
        .o_emit          (emit),
        .o_result        (frame_result)
    );

    lfcr_out_buf u_out_buf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (emit),
        .i_result (frame_result),
        .o_full   (buf_full),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_result (out_result)
    );

    // pack the output beat, first field in the low bits
    assign o_m_axis_tdata = {out_result.frame_length,
                             out_result.blue,
                             out_result.green,
                             out_result.red,
                             out_result.pixel_y,
                             out_result.pixel_x,
                             out_result.command};
    assign o_m_axis_tuser = out_result.is_setpixel;

endmodule
